[hw/rtl/cta_pkg.sv]
`default_nettype none

package cta_pkg;

    localparam int COORD_W = 16;
    localparam int LABEL_W = 16;
    localparam int RADIUS_W = 15;
    localparam int LIMIT_W = 2 * RADIUS_W;
    localparam int SQ_W = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd500;
    localparam logic [LABEL_W-1:0] LABEL_FIRST = 16'd1;
    localparam logic [LABEL_W-1:0] LABEL_LAST = 16'hFFFF;
    localparam logic [LABEL_W-1:0] LABEL_NONE = 16'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic                      frame_end;
        logic                      no_center;
    } center_t;

    typedef struct packed {
        logic [LABEL_W-1:0] track_id;
        logic               is_new;
        logic               dropped;
        logic               last_of_frame;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LABEL_W-1:0]        label;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/cta_sq_unit.sv]
`default_nettype none

// Shared squarer: radius squared and per-axis distance squared.
module cta_sq_unit (
    input  wire logic [cta_pkg::COORD_W-1:0] operand,
    output logic [cta_pkg::SQ_W-1:0]         square
);

    assign square = cta_pkg::SQ_W'(operand) * cta_pkg::SQ_W'(operand);

endmodule

`default_nettype wire

[hw/rtl/cta_table.sv]
`default_nettype none

// Two-bank track table; bank bit is the address MSB.
module cta_table #(
    parameter int ADDR_W = 5
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire cta_pkg::entry_t       wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output cta_pkg::entry_t            rd_data
);

    cta_pkg::entry_t mem [0:(2**ADDR_W)-1];
    cta_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/cluster_track_association.sv]
`default_nettype none
// Each accepted center walks the previous-frame entries in the READ state: a claimed
//   entry is skipped, an unclaimed one goes on through SQX, SQY and CMP, as the single
//   shared squarer takes one axis at a time. A dropped center goes from START to DONE.
// A new center is taken only in IDLE, once the last one is through; DONE waits for a free output.
// Reset (rst_n, async low): idle, both tables empty, label counter 1, radius 500 mm.
//   Table contents are not cleared; only entries below the fill count are read.
module cluster_track_association #(
    parameter int MAX_TRACKS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [cta_pkg::RADIUS_W-1:0]     cfg_wr_data,
    input  wire logic                             center_valid,
    output logic                                  center_ready,
    input  wire cta_pkg::center_t                 center,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output cta_pkg::result_t                      result
);

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int ADDR_W = IDX_W + 1;

    // Sequencer state
    cta_pkg::state_t state_reg;
    cta_pkg::state_t state_next;

    // Configuration and persistent frame state
    logic [cta_pkg::RADIUS_W-1:0] radius_reg;
    logic                         bank_reg;      // half that holds the previous frame
    logic [CNT_W-1:0]             old_count_reg;
    logic [CNT_W-1:0]             new_count_reg;
    logic [MAX_TRACKS-1:0]        claimed_reg;
    logic [cta_pkg::LABEL_W-1:0]  next_label_reg;

    // Search state
    logic [CNT_W-1:0]             idx_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             found_reg;
    logic [cta_pkg::LABEL_W-1:0]  best_label_reg;
    logic [cta_pkg::DIST_W-1:0]   best_reg;
    logic [cta_pkg::DIST_W-1:0]   acc_reg;
    logic [cta_pkg::LIMIT_W-1:0]  limit_reg;
    cta_pkg::center_t             item_reg;
    cta_pkg::result_t             res_reg;

    // Output stage
    logic                         out_valid_reg;
    cta_pkg::result_t             out_reg;

    // Control decoded from state
    logic do_swap_empty;
    logic do_drop;
    logic do_start;
    logic do_skip;
    logic do_read;
    logic do_finish;
    logic do_sqx;
    logic do_sqy;
    logic do_cmp;
    logic do_deliver;

    logic [IDX_W-1:0]             idx_sel;
    logic                         table_full;
    logic                         walk_done;
    logic                         out_free;
    logic                         last_item;

    // Datapath
    cta_pkg::entry_t              rd_entry;
    cta_pkg::entry_t              wr_entry;
    logic [cta_pkg::COORD_W:0]    diff_x;
    logic [cta_pkg::COORD_W:0]    diff_y;
    logic [cta_pkg::COORD_W:0]    neg_x;
    logic [cta_pkg::COORD_W:0]    neg_y;
    logic [cta_pkg::COORD_W-1:0]  mag_x;
    logic [cta_pkg::COORD_W-1:0]  mag_y;
    logic [cta_pkg::COORD_W-1:0]  sq_operand;
    logic [cta_pkg::SQ_W-1:0]     sq_result;
    logic [cta_pkg::LABEL_W-1:0]  issued_label;
    logic                         closer;

    assign idx_sel    = idx_reg[IDX_W-1:0];
    assign table_full = (new_count_reg >= CNT_W'(MAX_TRACKS));
    assign walk_done  = (idx_reg >= old_count_reg);
    assign out_free   = !out_valid_reg || result_ready;
    assign last_item  = item_reg.frame_end;

    assign center_ready = (state_reg == cta_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cta_pkg::ST_IDLE:
            begin
                if (center_valid)
                begin
                    state_next = cta_pkg::ST_START;
                end
            end
            cta_pkg::ST_START:
            begin
                if (item_reg.no_center)
                begin
                    state_next = cta_pkg::ST_IDLE;
                end
                else if (table_full)
                begin
                    state_next = cta_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cta_pkg::ST_READ;
                end
            end
            cta_pkg::ST_READ:
            begin
                if (walk_done)
                begin
                    state_next = cta_pkg::ST_DONE;
                end
                else if (!claimed_reg[idx_sel])
                begin
                    state_next = cta_pkg::ST_SQX;
                end
            end
            cta_pkg::ST_SQX:  state_next = cta_pkg::ST_SQY;
            cta_pkg::ST_SQY:  state_next = cta_pkg::ST_CMP;
            cta_pkg::ST_CMP:  state_next = cta_pkg::ST_READ;
            cta_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cta_pkg::ST_IDLE;
                end
            end
            default: state_next = cta_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        do_swap_empty = 1'b0;
        do_drop       = 1'b0;
        do_start      = 1'b0;
        do_skip       = 1'b0;
        do_read       = 1'b0;
        do_finish     = 1'b0;
        do_sqx        = 1'b0;
        do_sqy        = 1'b0;
        do_cmp        = 1'b0;
        do_deliver    = 1'b0;
        unique case (state_reg)
            cta_pkg::ST_IDLE: ;
            cta_pkg::ST_START:
            begin
                do_swap_empty = item_reg.no_center && last_item;
                do_drop       = !item_reg.no_center && table_full;
                do_start      = !item_reg.no_center && !table_full;
            end
            cta_pkg::ST_READ:
            begin
                do_finish = walk_done;
                do_skip   = !walk_done && claimed_reg[idx_sel];
                do_read   = !walk_done && !claimed_reg[idx_sel];
            end
            cta_pkg::ST_SQX:  do_sqx = 1'b1;
            cta_pkg::ST_SQY:  do_sqy = 1'b1;
            cta_pkg::ST_CMP:  do_cmp = 1'b1;
            cta_pkg::ST_DONE: do_deliver = out_free;
            default: ;
        endcase
    end

    // Per-axis magnitude of the difference; fits 16 bits unsigned
    assign diff_x = {item_reg.center_x[cta_pkg::COORD_W-1], item_reg.center_x}
                  - {rd_entry.x[cta_pkg::COORD_W-1], rd_entry.x};
    assign diff_y = {item_reg.center_y[cta_pkg::COORD_W-1], item_reg.center_y}
                  - {rd_entry.y[cta_pkg::COORD_W-1], rd_entry.y};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign mag_x  = diff_x[cta_pkg::COORD_W] ? neg_x[cta_pkg::COORD_W-1:0]
                                             : diff_x[cta_pkg::COORD_W-1:0];
    assign mag_y  = diff_y[cta_pkg::COORD_W] ? neg_y[cta_pkg::COORD_W-1:0]
                                             : diff_y[cta_pkg::COORD_W-1:0];

    always_comb
    begin
        if (do_sqx)
        begin
            sq_operand = mag_x;
        end
        else if (do_sqy)
        begin
            sq_operand = mag_y;
        end
        else
        begin
            sq_operand = cta_pkg::COORD_W'(radius_reg);
        end
    end

    cta_sq_unit u_sq (
        .operand (sq_operand),
        .square  (sq_result)
    );

    // strict limit; strictly closer so ties keep the earliest entry
    assign closer = (acc_reg < cta_pkg::DIST_W'(limit_reg))
                 && (!hit_reg || (acc_reg < best_reg));

    assign issued_label = hit_reg ? best_label_reg : next_label_reg;

    assign wr_entry.x     = item_reg.center_x;
    assign wr_entry.y     = item_reg.center_y;
    assign wr_entry.label = issued_label;

    cta_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (do_finish),
        .wr_addr ({~bank_reg, new_count_reg[IDX_W-1:0]}),
        .wr_data (wr_entry),
        .rd_en   (do_read),
        .rd_addr ({bank_reg, idx_sel}),
        .rd_data (rd_entry)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cta_pkg::ST_IDLE;
            radius_reg     <= cta_pkg::RADIUS_RESET;
            bank_reg       <= 1'b0;
            old_count_reg  <= '0;
            new_count_reg  <= '0;
            claimed_reg    <= '0;
            next_label_reg <= cta_pkg::LABEL_FIRST;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end

            if (do_start)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (do_skip || do_cmp)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (do_cmp && closer)
            begin
                hit_reg <= 1'b1;
            end

            if (do_finish)
            begin
                new_count_reg <= new_count_reg + 1'b1;
                if (hit_reg)
                begin
                    claimed_reg[found_reg] <= 1'b1;
                end
                else if (next_label_reg == cta_pkg::LABEL_LAST)
                begin
                    next_label_reg <= cta_pkg::LABEL_FIRST;
                end
                else
                begin
                    next_label_reg <= next_label_reg + 1'b1;
                end
            end

            // frame end: current table becomes the previous one
            if (do_swap_empty || (do_deliver && last_item))
            begin
                bank_reg      <= ~bank_reg;
                old_count_reg <= do_finish ? new_count_reg + 1'b1 : new_count_reg;
                new_count_reg <= '0;
                claimed_reg   <= '0;
            end

            if (do_deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (center_valid && center_ready)
        begin
            item_reg <= center;
        end
        if (do_start)
        begin
            limit_reg <= sq_result[cta_pkg::LIMIT_W-1:0];
        end
        if (do_sqx)
        begin
            acc_reg <= cta_pkg::DIST_W'(sq_result);
        end
        if (do_sqy)
        begin
            acc_reg <= acc_reg + cta_pkg::DIST_W'(sq_result);
        end
        if (do_cmp && closer)
        begin
            best_reg       <= acc_reg;
            found_reg      <= idx_sel;
            best_label_reg <= rd_entry.label;
        end
        if (do_drop)
        begin
            res_reg.track_id      <= cta_pkg::LABEL_NONE;
            res_reg.is_new        <= 1'b0;
            res_reg.dropped       <= 1'b1;
            res_reg.last_of_frame <= last_item;
        end
        if (do_finish)
        begin
            res_reg.track_id      <= issued_label;
            res_reg.is_new        <= ~hit_reg;
            res_reg.dropped       <= 1'b0;
            res_reg.last_of_frame <= last_item;
        end
        if (do_deliver)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cta_checker.sv]
`default_nettype none

module cta_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              center_valid,
    input wire logic              center_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire cta_pkg::result_t  result
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

    // track id is zero exactly for dropped centers
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.track_id == cta_pkg::LABEL_NONE) == result.dropped))
    else $error("track id zero does not match dropped");

    // a dropped center never uses a fresh label
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped |-> !result.is_new)
    else $error("dropped result flagged new");

    // the sequencer is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && center_ready |=> !center_ready)
    else $error("ready right after accept");

endmodule

bind cluster_track_association cta_checker u_cta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .center_valid (center_valid),
    .center_ready (center_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
